### design/whole_word_occurrence_counter_top_assert.svh
// Assertion macros shared by the checker of the whole-word occurrence counter.
`ifndef WHOLE_WORD_OCCURRENCE_COUNTER_TOP_ASSERT_SVH
`define WHOLE_WORD_OCCURRENCE_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define WWOC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("whole-word counter check failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define WWOC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("whole-word counter check failed");

`endif

### design/wwoc_pkg.sv
// Shared types, constants and helpers of the whole-word occurrence counter.
package wwoc_pkg;

  localparam int REG_CHARS  = 24;
  localparam int LEN_W      = 5;
  localparam int CNT_W      = 16;
  localparam int CHAR_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  // Wide enough to hold a pattern length, a window fill count, or two pattern positions plus one.
  localparam int CMP_W      = 6;

  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_PERIOD  = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW,
    CFG_PAT_MID,
    CFG_PAT_HIGH,
    CFG_PAT_LEN
  } cfg_reg_t;

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

### design/whole_word_occurrence_counter_top.sv
// Top level of the whole-word occurrence counter.
// Takes one text character per cycle, sustained, as long as results are taken
// when offered. An accepted item sits in the input register, where the whole
// pattern is compared against the character window in parallel, and the
// count for a text is loaded into the output register when its last
// character leaves the input register. A full output register stalls the
// input only while the item waiting in the input register is itself a last
// character. Configuration writes are taken every cycle and belong between
// texts.
module whole_word_occurrence_counter_top #(
  parameter int MAX_PATTERN = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] text_char
  input  logic                               in_tlast,   // end_of_text
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata,  // [15:0] match_count
  output logic                               out_tuser,  // count_saturated
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wwoc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wwoc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wwoc_pkg::*;

  localparam int PAT_CHARS = (MAX_PATTERN < REG_CHARS) ? MAX_PATTERN : REG_CHARS;

  logic [LEN_W-1:0]                  pat_len;
  logic [PAT_CHARS-1:0][CHAR_W-1:0]  pat_chars;
  logic                              stg_valid_r;
  logic [CHAR_W-1:0]                 stg_char_r;
  logic                              stg_last_r;
  logic                              advance;
  logic [CNT_W-1:0]                  res_count;
  logic                              res_sat;
  logic [CNT_W-1:0]                  out_count_r;
  logic                              out_sat_r;
  logic                              out_valid_r;

  wwoc_cfg #(.PAT_CHARS(PAT_CHARS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat_len   (pat_len),
    .pat_chars (pat_chars)
  );

  wwoc_core #(.PAT_CHARS(PAT_CHARS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .text_char (stg_char_r),
    .last      (stg_last_r),
    .pat_len   (pat_len),
    .pat_chars (pat_chars),
    .res_count (res_count),
    .res_sat   (res_sat)
  );

  // Only a last character needs room in the output register.
  assign advance   = stg_valid_r && (!stg_last_r || !out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_char_r <= in_tdata;
      stg_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && stg_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stg_last_r) begin
      out_count_r <= res_count;
      out_sat_r   <= res_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_count_r;
  assign out_tuser  = out_sat_r;

endmodule

### design/wwoc_cfg.sv
// Configuration registers and the length-aligned, case-folded pattern.
module wwoc_cfg #(
  parameter int PAT_CHARS = 24
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [wwoc_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [wwoc_pkg::CFG_DATA_W-1:0]             cfg_data,
  output logic [wwoc_pkg::LEN_W-1:0]                  pat_len,
  output logic [PAT_CHARS-1:0][wwoc_pkg::CHAR_W-1:0]  pat_chars
);
  import wwoc_pkg::*;

  logic [CFG_DATA_W-1:0]              pat_low_r;
  logic [CFG_DATA_W-1:0]              pat_mid_r;
  logic [CFG_DATA_W-1:0]              pat_high_r;
  logic [LEN_W-1:0]                   len_r;
  logic [REG_CHARS-1:0][CHAR_W-1:0]   reg_chars;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_mid_r  <= '0;
      pat_high_r <= '0;
      len_r      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PAT_LOW:  pat_low_r  <= cfg_data;
        CFG_PAT_MID:  pat_mid_r  <= cfg_data;
        CFG_PAT_HIGH: pat_high_r <= cfg_data;
        CFG_PAT_LEN:  len_r      <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign reg_chars = {pat_high_r, pat_mid_r, pat_low_r};

  // Lengths beyond what the window supports are clamped.
  assign pat_len = (len_r > LEN_W'(PAT_CHARS)) ? LEN_W'(PAT_CHARS) : len_r;

  // Reverse the pattern against the length so that position i lines up with
  // the character i places back in the window: the last pattern character
  // meets the newest text character.
  always_comb begin
    for (int i = 0; i < PAT_CHARS; i++) begin
      pat_chars[i] = '0;
      for (int k = 0; k < PAT_CHARS; k++) begin
        if ({1'b0, pat_len} == CMP_W'(k + i + 1)) begin
          pat_chars[i] = fold_char(reg_chars[k]);
        end
      end
    end
  end

endmodule

### design/wwoc_core.sv
// Character window, word match and saturating occurrence count.
module wwoc_core #(
  parameter int PAT_CHARS = 24
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        step,
  input  logic [wwoc_pkg::CHAR_W-1:0]                 text_char,
  input  logic                                        last,
  input  logic [wwoc_pkg::LEN_W-1:0]                  pat_len,
  input  logic [PAT_CHARS-1:0][wwoc_pkg::CHAR_W-1:0]  pat_chars,
  output logic [wwoc_pkg::CNT_W-1:0]                  res_count,
  output logic                                        res_sat
);
  import wwoc_pkg::*;

  localparam int WIN    = PAT_CHARS + 1;
  localparam int SEEN_W = $clog2(WIN + 1);

  typedef logic [WIN-1:0][CHAR_W-1:0] window_t;

  window_t             win_r;
  window_t             win_nxt;
  logic [SEEN_W-1:0]   seen_r;
  logic [SEEN_W-1:0]   seen_nxt;
  logic [CNT_W-1:0]    count_r;
  logic                sat_r;
  logic [CHAR_W-1:0]   c_fold;
  logic                delim;
  logic                hit_before;
  logic                hit_end;
  logic [1:0]          inc;
  logic [CNT_W:0]      sum;

  // True when the newest characters of w spell the pattern and the word
  // starts at the beginning of the text or right after a space.
  function automatic logic holds(input window_t w, input logic [SEEN_W-1:0] s,
                                 input logic [LEN_W-1:0] n,
                                 input logic [PAT_CHARS-1:0][CHAR_W-1:0] p);
    logic             all_eq;
    logic             sp;
    logic [CMP_W-1:0] n_x;
    logic [CMP_W-1:0] s_x;
    n_x    = CMP_W'(n);
    s_x    = CMP_W'(s);
    all_eq = 1'b1;
    sp     = 1'b0;
    for (int i = 0; i < PAT_CHARS; i++) begin
      if (CMP_W'(i) < n_x && w[i] != p[i]) begin
        all_eq = 1'b0;
      end
    end
    for (int k = 0; k < WIN; k++) begin
      if (n_x == CMP_W'(k)) begin
        sp = (w[k] == CHAR_SPACE);
      end
    end
    return (n_x != '0) && (s_x >= n_x) && all_eq && ((s_x == n_x) || sp);
  endfunction

  assign c_fold   = fold_char(text_char);
  assign delim    = (c_fold == CHAR_SPACE) || (c_fold == CHAR_COMMA) ||
                    (c_fold == CHAR_PERIOD);
  assign win_nxt  = {win_r[WIN-2:0], c_fold};
  assign seen_nxt = (seen_r == SEEN_W'(WIN)) ? seen_r : seen_r + 1'b1;

  // A delimiter can close a word that ended one character earlier, and the
  // final character can close another one in the same item.
  assign hit_before = delim && holds(win_r, seen_r, pat_len, pat_chars);
  assign hit_end    = last && holds(win_nxt, seen_nxt, pat_len, pat_chars);
  assign inc        = {1'b0, hit_before} + {1'b0, hit_end};
  assign sum        = {1'b0, count_r} + (CNT_W + 1)'(inc);
  assign res_count  = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
  assign res_sat    = sat_r | sum[CNT_W];

  always_ff @(posedge clk) begin
    if (step) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      count_r <= '0;
      sat_r   <= 1'b0;
    end else if (step) begin
      if (last) begin
        seen_r  <= '0;
        count_r <= '0;
        sat_r   <= 1'b0;
      end else begin
        seen_r  <= seen_nxt;
        count_r <= res_count;
        sat_r   <= res_sat;
      end
    end
  end

endmodule

### design/wwoc_checker.sv
// Port-level checker of the whole-word occurrence counter and its binding.
module wwoc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               in_tlast,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [15:0]                        out_tdata,
  input logic                               out_tuser
);
`include "whole_word_occurrence_counter_top_assert.svh"

  // A waiting result keeps its value until it is taken.
  `WWOC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // A saturated count always reads as the top value.
  `WWOC_ASSERT_IMP(a_sat_top, out_tvalid && out_tuser, out_tdata == 16'hFFFF)

  // A fresh result follows an accepted last character that has passed through the input register.
  `WWOC_ASSERT_IMP(a_out_from_last, $rose(out_tvalid), $past(in_tvalid && in_tready && in_tlast, 2))

  // With the output register empty the input never stalls.
  `WWOC_ASSERT_IMP(a_in_flows, !out_tvalid, in_tready)

endmodule

bind whole_word_occurrence_counter_top wwoc_checker u_wwoc_checker (.*);
